// ----- hw/rtl/uart_dual_ring_buffer_macros.svh -----
// Assertion macros shared by the ring buffer RTL.
`ifndef UART_DUAL_RING_BUFFER_MACROS_SVH
`define UART_DUAL_RING_BUFFER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UDRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UDRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/udrb_pkg.sv -----
// Package with the types and constants of the dual UART ring buffer.
`timescale 1ns / 1ps
package udrb_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 16;
    localparam int OP_W                 = 3;
    localparam int BYTE_W               = 8;
    localparam int RX_COUNT_W           = 4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 3'd0,
        OP_READ      = 3'd1,
        OP_RECEIVE   = 3'd2,
        OP_SLOT_FREE = 3'd3,
        OP_FLUSH     = 3'd4
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] data_byte;
        logic              line_error;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     out_byte;
        logic                  out_valid;
        logic                  accepted;
        logic [RX_COUNT_W-1:0] rx_count;
        logic                  tx_active;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/udrb_cell.sv -----
// One storage cell of a byte queue, loading a new byte or its neighbour's byte.
`timescale 1ns / 1ps
module udrb_cell (
    input  logic                         clk,
    input  udrb_pkg::cell_ctl_t          ctl,
    input  logic [udrb_pkg::BYTE_W-1:0]  new_byte,
    input  logic [udrb_pkg::BYTE_W-1:0]  neighbour_byte,
    output logic [udrb_pkg::BYTE_W-1:0]  cell_byte
);
    import udrb_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.load)
        begin
            byte_next = new_byte;
        end
        else if (ctl.shift)
        begin
            byte_next = neighbour_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

// ----- hw/rtl/udrb_queue.sv -----
// Byte queue built as a row of cells that shift towards the head on each pop.
`timescale 1ns / 1ps
module udrb_queue #(
    parameter int DEPTH = udrb_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                pop,
    input  logic                                clear,
    input  logic [udrb_pkg::BYTE_W-1:0]         push_byte,
    output logic [udrb_pkg::BYTE_W-1:0]         head_byte,
    output logic                                full,
    output logic                                empty,
    output logic [$clog2(DEPTH)-1:0]            count,
    output logic [$clog2(DEPTH)-1:0]            count_next
);
    import udrb_pkg::*;
    `include "uart_dual_ring_buffer_macros.svh"

    localparam int CW    = $clog2(DEPTH);
    localparam int NCELL = DEPTH - 1;

    logic [CW-1:0]     count_reg;
    logic [BYTE_W-1:0] cell_bytes [NCELL];

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [BYTE_W-1:0] neighbour;

        assign ctl = '{load:  push && !clear && (count_reg == CW'(i)),
                       shift: pop && !clear};

        if (i == NCELL - 1)
        begin : g_last
            assign neighbour = '0;
        end
        else
        begin : g_inner
            assign neighbour = cell_bytes[i + 1];
        end

        udrb_cell u_cell (
            .clk            (clk),
            .ctl            (ctl),
            .new_byte       (push_byte),
            .neighbour_byte (neighbour),
            .cell_byte      (cell_bytes[i])
        );
    end

    assign head_byte = cell_bytes[0];
    assign full      = (count_reg == CW'(NCELL));
    assign empty     = (count_reg == '0);
    assign count     = count_reg;

    `UDRB_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "Push into a full queue.")
    `UDRB_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty, "Pop from an empty queue.")
    `UDRB_ASSERT_NOW(a_one_command, clk, rst_n, push, !pop, "Push and pop in one cycle.")
    `UDRB_ASSERT_NEXT(a_push_count, clk, rst_n, push && !clear,
        count_reg == CW'($past(count_reg) + 1'b1), "Push did not raise the count by one.")
    `UDRB_ASSERT_NEXT(a_clear_empty, clk, rst_n, clear, empty, "Queue not empty after a clear.")

endmodule

// ----- hw/rtl/uart_dual_ring_buffer.sv -----
// Top level of the dual UART ring buffer: transmit and receive queues with a transmitter flag.
//
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid / req_stall   | udrb_pkg::req_t
// rsp     | out       | rsp_valid / rsp_stall   | udrb_pkg::rsp_t
//
// Each transaction is decoded combinationally and its result sits in the output register,
// so one transaction is taken per clock while the response side keeps up.
// The output register is the only stage; req_stall rises only while it holds a result
// that the response side stalls.
// Reset empties both queues, clears the transmitter flag and the output valid flag.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module uart_dual_ring_buffer #(
    parameter int BUFFER_DEPTH = udrb_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  udrb_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output udrb_pkg::rsp_t   rsp
);
    import udrb_pkg::*;

    localparam int CW = $clog2(BUFFER_DEPTH);

    logic              fire;
    logic              tx_push, tx_pop, rx_push, rx_pop, flush;
    logic [BYTE_W-1:0] tx_head_byte, rx_head_byte;
    logic              tx_full, tx_empty, rx_full, rx_empty;
    logic [CW-1:0]     tx_count, tx_count_next, rx_count_q, rx_count_next;
    logic [CW+RX_COUNT_W-1:0] rx_count_ext;

    logic tx_on_reg, tx_on_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign fire      = req_valid && !req_stall;

    always_comb
    begin
        tx_push    = 1'b0;
        tx_pop     = 1'b0;
        rx_push    = 1'b0;
        rx_pop     = 1'b0;
        flush      = 1'b0;
        tx_on_next = tx_on_reg;
        rsp_next   = '0;
        if (fire)
        begin
            case (req.operation)
                OP_WRITE:
                begin
                    if (!tx_full)
                    begin
                        tx_push           = 1'b1;
                        tx_on_next        = 1'b1;
                        rsp_next.accepted = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (!req.line_error && !rx_empty)
                    begin
                        rx_pop             = 1'b1;
                        rsp_next.out_byte  = rx_head_byte;
                        rsp_next.out_valid = 1'b1;
                    end
                end
                OP_RECEIVE:
                begin
                    if (!rx_full)
                    begin
                        rx_push           = 1'b1;
                        rsp_next.accepted = 1'b1;
                    end
                end
                OP_SLOT_FREE:
                begin
                    if (tx_on_reg)
                    begin
                        if (tx_empty)
                        begin
                            tx_on_next = 1'b0;
                        end
                        else
                        begin
                            tx_pop             = 1'b1;
                            rsp_next.out_byte  = tx_head_byte;
                            rsp_next.out_valid = 1'b1;
                            if (tx_count == CW'(1))
                            begin
                                tx_on_next = 1'b0;
                            end
                        end
                    end
                end
                OP_FLUSH:
                begin
                    flush = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        rx_count_ext       = {{RX_COUNT_W{1'b0}}, rx_count_next};
        rsp_next.rx_count  = req.line_error ? '0 : rx_count_ext[RX_COUNT_W-1:0];
        rsp_next.tx_active = tx_on_next;
    end

    always_comb
    begin
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_on_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            tx_on_reg     <= tx_on_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    udrb_queue #(
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tx_push),
        .pop        (tx_pop),
        .clear      (flush),
        .push_byte  (req.data_byte),
        .head_byte  (tx_head_byte),
        .full       (tx_full),
        .empty      (tx_empty),
        .count      (tx_count),
        .count_next (tx_count_next)
    );

    udrb_queue #(
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rx_push),
        .pop        (rx_pop),
        .clear      (flush),
        .push_byte  (req.data_byte),
        .head_byte  (rx_head_byte),
        .full       (rx_full),
        .empty      (rx_empty),
        .count      (rx_count_q),
        .count_next (rx_count_next)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `include "uart_dual_ring_buffer_macros.svh"

    `UDRB_ASSERT_NOW(a_tx_on_when_queued, clk, rst_n, !tx_empty, tx_on_reg,
        "Transmit bytes queued while the transmitter is inactive.")
    `UDRB_ASSERT_NEXT(a_stall_holds_rsp, clk, rst_n, rsp_valid_reg && rsp_stall,
        rsp_valid_reg && (rsp_reg == $past(rsp_reg)), "Stalled response changed.")
    `UDRB_ASSERT_NOW(a_rx_count_lines, clk, rst_n, rx_pop, rx_count_q != '0,
        "Host read from an empty receive queue.")
    `UDRB_ASSERT_NEXT(a_flush_empties, clk, rst_n, flush, tx_empty && rx_empty,
        "Flush left bytes queued.")
    `UDRB_ASSERT_NOW(a_tx_drain_flag, clk, rst_n, tx_pop,
        (tx_count_next == '0) == !tx_on_next,
        "Transmitter flag does not follow the draining of the transmit queue.")

endmodule
